// ----- rtl/core/enu_pkg.sv -----
`timescale 1ns / 1ps

package enu_pkg;

    localparam int NODES_DEFAULT      = 1024;
    localparam int MAX_DEGREE_DEFAULT = 32;

    localparam int CFG_ADDR_W = 3;

    localparam logic REG_THRESHOLD  = 1'b0;
    localparam logic REG_NODE_COUNT = 1'b1;

    localparam logic [10:0] NODE_COUNT_RESET = 11'd1024;
    localparam logic [10:0] COUNT_MAX        = 11'd2047;

    localparam logic [2:0] KIND_WR_NEIGHBOR = 3'd0;
    localparam logic [2:0] KIND_SET_DEGREE  = 3'd1;
    localparam logic [2:0] KIND_SET_STATE   = 3'd2;
    localparam logic [2:0] KIND_UPDATE      = 3'd3;
    localparam logic [2:0] KIND_COMMIT      = 3'd4;

    localparam logic [1:0] NODE_REFRACTORY = 2'd0;
    localparam logic [1:0] NODE_READY      = 2'd1;
    localparam logic [1:0] NODE_ACTIVE     = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [9:0]  node_index;
        logic [4:0]  slot;
        logic [9:0]  value;
        logic [15:0] random_draw;
    } item_t;

    typedef struct packed {
        logic [1:0]  node_state;
        logic        neighbor_active;
        logic [10:0] active_count;
    } result_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_APPLY,
        S_SCAN,
        S_FINISH,
        S_SWEEP,
        S_DONE
    } ctl_state_t;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_CURRENT,
        RES_WRITTEN,
        RES_UPDATE,
        RES_COMMIT
    } res_sel_t;

    typedef struct packed {
        logic     clear;
        logic     accept;
        logic     lookup;
        logic     wr_neighbor;
        logic     wr_degree;
        logic     wr_state;
        logic     scan_start;
        logic     sweep_start;
        logic     upd_write;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       scan_busy;
        logic       sweep_busy;
        logic       clear_last;
    } ctl_status_t;

endpackage

// ----- rtl/core/excitable_network_update_unit.sv -----
`timescale 1ns / 1ps
// Table and state writes go through lookup and apply, then their result is registered; an update
// also scans the node's neighbors up to its degree, one neighbor read per cycle through a three-deep
// read pipeline; a commit copies min(node_count, NODES) states, one state copied per cycle.
// One word at a time; the next word is taken once the result sits in the output register.
// Reset: asynchronous, active low; afterwards a pass over all NODES entries clears degree and
// both state planes, during which no word is taken. Neighbor table is not cleared.
module excitable_network_update_unit #(
    parameter int NODES      = enu_pkg::NODES_DEFAULT,
    parameter int MAX_DEGREE = enu_pkg::MAX_DEGREE_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  enu_pkg::item_t                  item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output enu_pkg::result_t                result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [enu_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    enu_pkg::ctl_cmd_t    cmd;
    enu_pkg::ctl_status_t status;
    logic [16:0]          threshold;
    logic [10:0]          node_count;

    enu_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .threshold  (threshold),
        .node_count (node_count)
    );

    enu_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    enu_datapath #(
        .NODES      (NODES),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .item       (item),
        .threshold  (threshold),
        .node_count (node_count),
        .status     (status),
        .result     (result)
    );

endmodule

// ----- rtl/core/enu_cfg.sv -----
`timescale 1ns / 1ps

module enu_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [enu_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [16:0]                     threshold,
    output logic [10:0]                     node_count
);

    logic [16:0] threshold_reg;
    logic [16:0] threshold_next;
    logic [10:0] node_count_reg;
    logic [10:0] node_count_next;
    logic        wr_en;
    logic        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_comb
    begin
        threshold_next  = threshold_reg;
        node_count_next = node_count_reg;
        if (wr_en)
        begin
            case (reg_idx)
                enu_pkg::REG_THRESHOLD:  threshold_next  = pwdata[16:0];
                enu_pkg::REG_NODE_COUNT: node_count_next = pwdata[10:0];
                default:                 threshold_next  = threshold_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= '0;
            node_count_reg <= enu_pkg::NODE_COUNT_RESET;
        end
        else
        begin
            threshold_reg  <= threshold_next;
            node_count_reg <= node_count_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            enu_pkg::REG_THRESHOLD:  prdata = {15'd0, threshold_reg};
            enu_pkg::REG_NODE_COUNT: prdata = {21'd0, node_count_reg};
            default:                 prdata = '0;
        endcase
    end

    assign threshold  = threshold_reg;
    assign node_count = node_count_reg;

endmodule

// ----- rtl/core/enu_ctrl.sv -----
`timescale 1ns / 1ps

module enu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    output logic                 result_valid,
    input  logic                 result_stall,
    input  enu_pkg::ctl_status_t status,
    output enu_pkg::ctl_cmd_t    cmd
);

    enu_pkg::ctl_state_t state_reg;
    enu_pkg::ctl_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            enu_pkg::S_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = enu_pkg::S_IDLE;
                end
            end
            enu_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = enu_pkg::S_LOOKUP;
                end
            end
            enu_pkg::S_LOOKUP:
            begin
                state_next = enu_pkg::S_APPLY;
            end
            enu_pkg::S_APPLY:
            begin
                case (status.kind)
                    enu_pkg::KIND_UPDATE: state_next = enu_pkg::S_SCAN;
                    enu_pkg::KIND_COMMIT: state_next = enu_pkg::S_SWEEP;
                    default:              state_next = enu_pkg::S_DONE;
                endcase
            end
            enu_pkg::S_SCAN:
            begin
                if (!status.scan_busy)
                begin
                    state_next = enu_pkg::S_FINISH;
                end
            end
            enu_pkg::S_FINISH:
            begin
                state_next = enu_pkg::S_DONE;
            end
            enu_pkg::S_SWEEP:
            begin
                if (!status.sweep_busy)
                begin
                    state_next = enu_pkg::S_DONE;
                end
            end
            enu_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = enu_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = enu_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            enu_pkg::S_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            enu_pkg::S_IDLE:
            begin
                item_stall = 1'b0;
                cmd.accept = item_valid;
            end
            enu_pkg::S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            enu_pkg::S_APPLY:
            begin
                case (status.kind)
                    enu_pkg::KIND_WR_NEIGHBOR:
                    begin
                        cmd.wr_neighbor = 1'b1;
                        cmd.res_load    = 1'b1;
                        cmd.res_sel     = enu_pkg::RES_CURRENT;
                    end
                    enu_pkg::KIND_SET_DEGREE:
                    begin
                        cmd.wr_degree = 1'b1;
                        cmd.res_load  = 1'b1;
                        cmd.res_sel   = enu_pkg::RES_CURRENT;
                    end
                    enu_pkg::KIND_SET_STATE:
                    begin
                        cmd.wr_state = 1'b1;
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = enu_pkg::RES_WRITTEN;
                    end
                    enu_pkg::KIND_UPDATE:
                    begin
                        cmd.scan_start = 1'b1;
                    end
                    enu_pkg::KIND_COMMIT:
                    begin
                        cmd.sweep_start = 1'b1;
                    end
                    default:
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = enu_pkg::RES_ZERO;
                    end
                endcase
            end
            enu_pkg::S_FINISH:
            begin
                cmd.upd_write = 1'b1;
                cmd.res_load  = 1'b1;
                cmd.res_sel   = enu_pkg::RES_UPDATE;
            end
            enu_pkg::S_SWEEP:
            begin
                cmd.res_load = !status.sweep_busy;
                cmd.res_sel  = enu_pkg::RES_COMMIT;
            end
            enu_pkg::S_DONE:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= enu_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

// ----- rtl/core/enu_datapath.sv -----
`timescale 1ns / 1ps

module enu_datapath #(
    parameter int NODES      = enu_pkg::NODES_DEFAULT,
    parameter int MAX_DEGREE = enu_pkg::MAX_DEGREE_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  enu_pkg::ctl_cmd_t    cmd,
    input  enu_pkg::item_t       item,
    input  logic [16:0]          threshold,
    input  logic [10:0]          node_count,
    output enu_pkg::ctl_status_t status,
    output enu_pkg::result_t     result
);

    localparam int NODE_W   = $clog2(NODES);
    localparam int NB_DEPTH = NODES * MAX_DEGREE;
    localparam int NB_W     = $clog2(NB_DEPTH);
    localparam int DEG_W    = $clog2(MAX_DEGREE + 1);
    localparam int CNT_W    = $clog2(NODES + 1);

    logic [9:0]       nb_mem   [NB_DEPTH];
    logic [DEG_W-1:0] deg_mem  [NODES];
    logic [1:0]       prev_mem [NODES];
    logic [1:0]       cur_mem  [NODES];

    enu_pkg::item_t   item_reg;
    enu_pkg::result_t res_reg;
    enu_pkg::result_t res_next;
    enu_pkg::result_t out_reg;
    logic [NB_W-1:0]   base_reg;
    logic [9:0]        nb_q;
    logic [DEG_W-1:0]  deg_q;
    logic [1:0]        prev_q;
    logic [1:0]        cur_q;
    logic [1:0]        old_reg;
    logic [1:0]        cur_old_reg;
    logic              hit_reg;
    logic [10:0]       count_reg;
    logic [NODE_W-1:0] sw1_idx_reg;

    logic [NODE_W-1:0] clr_idx_reg;
    logic [DEG_W-1:0]  ptr_reg;
    logic [DEG_W-1:0]  cnt_reg;
    logic              p1_valid_reg;
    logic              p2_valid_reg;
    logic [CNT_W-1:0]  sweep_idx_reg;
    logic [CNT_W-1:0]  sweep_lim_reg;
    logic              sw1_valid_reg;

    logic              node_ok;
    logic              slot_ok;
    logic              state_ok;
    logic [NODE_W-1:0] node_addr;
    logic              scan_issue;
    logic              sweep_issue;
    logic              nb_in_range;
    logic [DEG_W-1:0]  deg_sat;
    logic [CNT_W-1:0]  lim;
    logic [1:0]        new_state;

    logic              nb_we;
    logic [NB_W-1:0]   nb_waddr;
    logic              deg_we;
    logic [NODE_W-1:0] deg_waddr;
    logic [DEG_W-1:0]  deg_wdata;
    logic              prev_we;
    logic [NODE_W-1:0] prev_waddr;
    logic [1:0]        prev_wdata;
    logic              cur_we;
    logic [NODE_W-1:0] cur_waddr;
    logic [1:0]        cur_wdata;
    logic              prev_re;
    logic [NODE_W-1:0] prev_raddr;
    logic              cur_re;
    logic [NODE_W-1:0] cur_raddr;

    assign node_ok     = int'(item_reg.node_index) < NODES;
    assign slot_ok     = int'(item_reg.slot) < MAX_DEGREE;
    assign state_ok    = item_reg.value <= {8'd0, enu_pkg::NODE_ACTIVE};
    assign node_addr   = NODE_W'(item_reg.node_index);
    assign scan_issue  = ptr_reg < cnt_reg;
    assign sweep_issue = sweep_idx_reg < sweep_lim_reg;
    assign nb_in_range = int'(nb_q) < NODES;
    assign deg_sat     = (int'(item_reg.value) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE)
                                                             : DEG_W'(item_reg.value);
    assign lim         = (int'(node_count) > NODES) ? CNT_W'(NODES) : CNT_W'(node_count);

    always_comb
    begin
        case (old_reg)
            enu_pkg::NODE_REFRACTORY:
            begin
                new_state = enu_pkg::NODE_READY;
            end
            enu_pkg::NODE_READY:
            begin
                if (hit_reg && ({1'b0, item_reg.random_draw} < threshold))
                begin
                    new_state = enu_pkg::NODE_ACTIVE;
                end
                else
                begin
                    new_state = cur_old_reg;
                end
            end
            default:
            begin
                new_state = enu_pkg::NODE_REFRACTORY;
            end
        endcase
    end

    // write ports
    assign nb_we    = cmd.wr_neighbor && node_ok && slot_ok;
    assign nb_waddr = base_reg + NB_W'(item_reg.slot);

    always_comb
    begin
        deg_we    = 1'b0;
        deg_waddr = node_addr;
        deg_wdata = deg_sat;
        if (cmd.clear)
        begin
            deg_we    = 1'b1;
            deg_waddr = clr_idx_reg;
            deg_wdata = '0;
        end
        else if (cmd.wr_degree)
        begin
            deg_we = node_ok;
        end
    end

    always_comb
    begin
        prev_we    = 1'b0;
        prev_waddr = node_addr;
        prev_wdata = item_reg.value[1:0];
        if (cmd.clear)
        begin
            prev_we    = 1'b1;
            prev_waddr = clr_idx_reg;
            prev_wdata = enu_pkg::NODE_REFRACTORY;
        end
        else if (sw1_valid_reg)
        begin
            prev_we    = 1'b1;
            prev_waddr = sw1_idx_reg;
            prev_wdata = cur_q;
        end
        else if (cmd.wr_state)
        begin
            prev_we = node_ok && state_ok;
        end
    end

    always_comb
    begin
        cur_we    = 1'b0;
        cur_waddr = node_addr;
        cur_wdata = item_reg.value[1:0];
        if (cmd.clear)
        begin
            cur_we    = 1'b1;
            cur_waddr = clr_idx_reg;
            cur_wdata = enu_pkg::NODE_REFRACTORY;
        end
        else if (cmd.wr_state)
        begin
            cur_we = node_ok && state_ok;
        end
        else if (cmd.upd_write)
        begin
            cur_we    = node_ok;
            cur_wdata = new_state;
        end
    end

    // read ports
    assign prev_re    = cmd.lookup || p1_valid_reg;
    assign prev_raddr = p1_valid_reg ? NODE_W'(nb_q) : node_addr;
    assign cur_re     = cmd.lookup || sweep_issue;
    assign cur_raddr  = sweep_issue ? sweep_idx_reg[NODE_W-1:0] : node_addr;

    always_ff @(posedge clk)
    begin
        if (nb_we)
        begin
            nb_mem[nb_waddr] <= item_reg.value;
        end
        if (scan_issue)
        begin
            nb_q <= nb_mem[base_reg + NB_W'(ptr_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        if (cmd.lookup)
        begin
            deg_q <= deg_mem[node_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (prev_re)
        begin
            prev_q <= prev_mem[prev_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[cur_waddr] <= cur_wdata;
        end
        if (cur_re)
        begin
            cur_q <= cur_mem[cur_raddr];
        end
    end

    // sequencing counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg   <= '0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            sweep_idx_reg <= '0;
            sweep_lim_reg <= '0;
            sw1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.scan_start)
            begin
                ptr_reg <= '0;
                cnt_reg <= node_ok ? deg_q : '0;
            end
            else if (scan_issue)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            p1_valid_reg <= scan_issue;
            p2_valid_reg <= p1_valid_reg && nb_in_range;
            if (cmd.sweep_start)
            begin
                sweep_idx_reg <= '0;
                sweep_lim_reg <= lim;
            end
            else if (sweep_issue)
            begin
                sweep_idx_reg <= sweep_idx_reg + 1'b1;
            end
            sw1_valid_reg <= sweep_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= item;
        end
        if (cmd.lookup)
        begin
            base_reg <= NB_W'(node_addr * MAX_DEGREE);
        end
        if (cmd.scan_start)
        begin
            old_reg     <= prev_q;
            cur_old_reg <= cur_q;
            hit_reg     <= 1'b0;
        end
        else if (p2_valid_reg && (prev_q == enu_pkg::NODE_ACTIVE))
        begin
            hit_reg <= 1'b1;
        end
        if (cmd.sweep_start)
        begin
            count_reg <= '0;
        end
        else if (sw1_valid_reg && (cur_q == enu_pkg::NODE_ACTIVE)
                 && (count_reg != enu_pkg::COUNT_MAX))
        begin
            count_reg <= count_reg + 1'b1;
        end
        sw1_idx_reg <= sweep_idx_reg[NODE_W-1:0];
    end

    always_comb
    begin
        res_next = res_reg;
        if (cmd.res_load)
        begin
            res_next = '0;
            case (cmd.res_sel)
                enu_pkg::RES_CURRENT:
                begin
                    res_next.node_state = node_ok ? cur_q : enu_pkg::NODE_REFRACTORY;
                end
                enu_pkg::RES_WRITTEN:
                begin
                    if (!node_ok)
                    begin
                        res_next.node_state = enu_pkg::NODE_REFRACTORY;
                    end
                    else
                    begin
                        res_next.node_state = state_ok ? item_reg.value[1:0] : cur_q;
                    end
                end
                enu_pkg::RES_UPDATE:
                begin
                    res_next.node_state      = node_ok ? new_state
                                                       : enu_pkg::NODE_REFRACTORY;
                    res_next.neighbor_active = node_ok && hit_reg;
                end
                enu_pkg::RES_COMMIT:
                begin
                    res_next.active_count = count_reg;
                end
                default:
                begin
                    res_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign status.kind       = item_reg.kind;
    assign status.scan_busy  = scan_issue || p1_valid_reg || p2_valid_reg;
    assign status.sweep_busy = sweep_issue || sw1_valid_reg;
    assign status.clear_last = clr_idx_reg == NODE_W'(NODES - 1);

    assign result = out_reg;

endmodule

// ----- rtl/core/enu_checker.sv -----
`timescale 1ns / 1ps

module enu_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input logic             result_valid,
    input logic             result_stall,
    input enu_pkg::result_t result
);

    // held result word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result word changed");

    // one word in flight: input closes right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input open right after accept");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.node_state != 2'd3)
        else $error("illegal node state in result");

    // commit results carry only a count
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.active_count != 11'd0)
            |-> (result.node_state == enu_pkg::NODE_REFRACTORY) && !result.neighbor_active)
        else $error("count mixed with node fields");

endmodule

bind excitable_network_update_unit enu_checker u_enu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import enu_pkg::*;

    localparam int NODE_TOTAL      = NODES_DEFAULT;
    localparam int DEG_MAX         = MAX_DEGREE_DEFAULT;
    localparam int HOT_NODES       = 32;
    localparam int PHASES          = 10;
    localparam int WORDS_PER_PHASE = 150;
    localparam int LIMIT_CYCLES    = 2000000;

    // Mirrors the node tables and checks results in order of arrival.
    class network_scoreboard;
        logic [9:0]  nbr_tab [0:NODE_TOTAL*DEG_MAX-1];
        bit          nbr_set [0:NODE_TOTAL*DEG_MAX-1];
        logic [5:0]  degree  [0:NODE_TOTAL-1];
        logic [1:0]  prev_st [0:NODE_TOTAL-1];
        logic [1:0]  cur_st  [0:NODE_TOTAL-1];
        logic [16:0] threshold;
        logic [10:0] node_count;
        result_t     expected_q [$];
        int          errors;
        int          checked;

        function new();
            for (int i = 0; i < NODE_TOTAL; i++)
            begin
                degree[i]  = '0;
                prev_st[i] = NODE_REFRACTORY;
                cur_st[i]  = NODE_REFRACTORY;
            end
            threshold  = '0;
            node_count = NODE_COUNT_RESET;
            errors     = 0;
            checked    = 0;
        endfunction

        function void report(string msg);
            $display("ERROR: result %0d: %s", checked, msg);
            errors++;
        endfunction

        function void set_reg(logic idx, logic [31:0] val);
            if (idx == REG_THRESHOLD)
                threshold = val[16:0];
            else
                node_count = val[10:0];
        endfunction

        // first slot below the degree that was never written, -1 if none
        function int open_slot(logic [9:0] n);
            for (int i = 0; i < degree[n]; i++)
            begin
                if (!nbr_set[int'(n) * DEG_MAX + i])
                    return i;
            end
            return -1;
        endfunction

        function void note_item(item_t w);
            result_t r;
            logic    hit;
            int      lim;
            int      cnt;
            int      base;
            r    = '0;
            hit  = 1'b0;
            cnt  = 0;
            base = int'(w.node_index) * DEG_MAX;
            case (w.kind)
                KIND_WR_NEIGHBOR:
                begin
                    nbr_tab[base + int'(w.slot)] = w.value;
                    nbr_set[base + int'(w.slot)] = 1'b1;
                end
                KIND_SET_DEGREE:
                    degree[w.node_index] = (w.value > DEG_MAX) ? 6'(DEG_MAX) : w.value[5:0];
                KIND_SET_STATE:
                begin
                    if (w.value <= NODE_ACTIVE)
                    begin
                        prev_st[w.node_index] = w.value[1:0];
                        cur_st[w.node_index]  = w.value[1:0];
                    end
                end
                KIND_UPDATE:
                begin
                    for (int i = 0; i < degree[w.node_index]; i++)
                    begin
                        if (prev_st[nbr_tab[base + i]] == NODE_ACTIVE)
                            hit = 1'b1;
                    end
                    case (prev_st[w.node_index])
                        NODE_REFRACTORY:
                            cur_st[w.node_index] = NODE_READY;
                        NODE_READY:
                        begin
                            if (hit && w.random_draw < threshold)
                                cur_st[w.node_index] = NODE_ACTIVE;
                        end
                        default:
                            cur_st[w.node_index] = NODE_REFRACTORY;
                    endcase
                    r.neighbor_active = hit;
                end
                KIND_COMMIT:
                begin
                    lim = (node_count > NODE_TOTAL) ? NODE_TOTAL : int'(node_count);
                    for (int i = 0; i < lim; i++)
                    begin
                        prev_st[i] = cur_st[i];
                        if (cur_st[i] == NODE_ACTIVE)
                            cnt++;
                    end
                    r.active_count = 11'(cnt);
                end
                default: ;
            endcase
            if (w.kind <= KIND_UPDATE)
                r.node_state = cur_st[w.node_index];
            expected_q.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                report("result word with nothing expected");
                return;
            end
            want = expected_q.pop_front();
            if (got.node_state !== want.node_state)
                report($sformatf("node_state %0d, expected %0d",
                                 got.node_state, want.node_state));
            if (got.neighbor_active !== want.neighbor_active)
                report($sformatf("neighbor_active %0d, expected %0d",
                                 got.neighbor_active, want.neighbor_active));
            if (got.active_count !== want.active_count)
                report($sformatf("active_count %0d, expected %0d",
                                 got.active_count, want.active_count));
        endfunction
    endclass

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    item_t                 item         = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr        = '0;
    logic [31:0]           pwdata       = '0;
    logic [31:0]           prdata;
    logic                  pready;

    bit                    quiet        = 1'b0;
    int                    stall_left   = 0;
    logic                  res_taken    = 1'b0;
    int                    cycle        = 0;
    network_scoreboard     sb           = new();

    excitable_network_update_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle >= LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int idle_draw();
        return quiet ? 0 : int'($urandom_range(0, 4));
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            sb.note_item(item);
    end

    always @(posedge clk)
    begin
        res_taken <= rst_n && result_valid && !result_stall;
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    always @(negedge clk)
    begin
        if (res_taken)
            stall_left = idle_draw();
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else
            result_stall <= 1'b0;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(item_t w);
        int gap;
        gap = idle_draw();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       <= w;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk);
    endtask

    task automatic cfg_write(logic idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic cfg_check(logic idx, logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
            sb.report($sformatf("register %0d reads %0h, expected %0h", idx, prdata, want));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    function automatic item_t word_of(logic [2:0] k, logic [9:0] n, logic [4:0] s,
                                      logic [9:0] v, logic [15:0] d);
        item_t w;
        w.kind        = k;
        w.node_index  = n;
        w.slot        = s;
        w.value       = v;
        w.random_draw = d;
        return w;
    endfunction

    function automatic logic [9:0] pick_node();
        if ($urandom_range(0, 99) < 85)
            return 10'($urandom_range(0, HOT_NODES - 1));
        return 10'($urandom_range(0, NODE_TOTAL - 1));
    endfunction

    function automatic item_t make_word();
        item_t       w;
        int          r;
        int          gap_slot;
        logic [16:0] below;
        w = word_of(3'($urandom), pick_node(), 5'($urandom), 10'($urandom), 16'($urandom));
        r = $urandom_range(0, 99);
        if (r < 20)
        begin
            w.kind  = KIND_WR_NEIGHBOR;
            w.value = pick_node();
        end
        else if (r < 30)
        begin
            w.kind = KIND_SET_DEGREE;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: w.value = 10'($urandom_range(0, 8));
                4, 5, 6, 7: w.value = 10'($urandom_range(0, DEG_MAX));
                default:    w.value = 10'($urandom_range(DEG_MAX + 1, 1023));
            endcase
        end
        else if (r < 40)
        begin
            w.kind = KIND_SET_STATE;
            if ($urandom_range(0, 9) != 0)
                w.value = 10'($urandom_range(0, 3));
        end
        else if (r < 95)
        begin
            gap_slot = sb.open_slot(w.node_index);
            if (gap_slot >= 0)
            begin
                // fill the neighbor list before the node may be updated
                w.kind  = KIND_WR_NEIGHBOR;
                w.slot  = 5'(gap_slot);
                w.value = pick_node();
            end
            else
            begin
                w.kind = KIND_UPDATE;
                below  = sb.threshold - 17'd1;
                case ($urandom_range(0, 9))
                    0:       w.random_draw = 16'h0000;
                    1:       w.random_draw = 16'hFFFF;
                    2:       w.random_draw = below[15:0];
                    3:       w.random_draw = sb.threshold[15:0];
                    default: ;
                endcase
            end
        end
        else if (r < 98)
            w.kind = KIND_COMMIT;
        else
            w.kind = KIND_COMMIT + 3'($urandom_range(1, 3));
        return w;
    endfunction

    initial
    begin
        logic [31:0] thr;
        logic [31:0] cnt;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_word(word_of(KIND_SET_STATE, 10'd0, 5'd0, 10'(NODE_ACTIVE), 16'h0000));
        send_word(word_of(KIND_SET_STATE, 10'd1023, 5'd31, 10'(NODE_ACTIVE) + 10'd1, 16'hFFFF));
        send_word(word_of(KIND_SET_STATE, 10'd1023, 5'd0, 10'(NODE_ACTIVE), 16'h0000));
        send_word(word_of(KIND_WR_NEIGHBOR, 10'd5, 5'd0, 10'd1023, 16'h0000));
        send_word(word_of(KIND_WR_NEIGHBOR, 10'd5, 5'd1, 10'd0, 16'hFFFF));
        send_word(word_of(KIND_WR_NEIGHBOR, 10'd1023, 5'd31, 10'd1023, 16'h0000));
        send_word(word_of(KIND_SET_DEGREE, 10'd5, 5'd0, 10'd2, 16'h0000));
        send_word(word_of(KIND_UPDATE, 10'd5, 5'd0, 10'd0, 16'h0000));
        send_word(word_of(KIND_COMMIT, 10'd0, 5'd0, 10'd0, 16'h0000));
        send_word(word_of(KIND_UPDATE, 10'd5, 5'd31, 10'd1023, 16'h0000));
        send_word(word_of(KIND_UPDATE, 10'd7, 5'd0, 10'd0, 16'hFFFF));
        send_word(word_of(KIND_UPDATE, 10'd0, 5'd0, 10'd0, 16'h0000));
        send_word(word_of(KIND_SET_DEGREE, 10'd6, 5'd0, 10'd1023, 16'h0000));
        send_word(word_of(KIND_SET_DEGREE, 10'd6, 5'd0, 10'(DEG_MAX + 1), 16'h0000));
        send_word(word_of(KIND_SET_STATE, 10'd1, 5'd0, 10'(NODE_READY), 16'h0000));
        send_word(word_of(KIND_UPDATE, 10'd1, 5'd0, 10'd0, 16'h0000));
        send_word(word_of(KIND_COMMIT + 3'd1, 10'd1023, 5'd31, 10'd1023, 16'hFFFF));
        send_word(word_of(KIND_COMMIT + 3'd3, 10'd1023, 5'd31, 10'd1023, 16'hFFFF));
        send_word(word_of(KIND_COMMIT, 10'd1023, 5'd31, 10'd1023, 16'hFFFF));
        send_word(word_of(KIND_SET_DEGREE, 10'd6, 5'd0, 10'd0, 16'h0000));
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin thr = 32'd65536;  cnt = 32'd1024; end
                1:       begin thr = 32'd131071; cnt = 32'd2047; end
                2:       begin thr = 32'd32768;  cnt = 32'd40;   end
                3:       begin thr = 32'd1;      cnt = 32'd0;    end
                4:       begin thr = 32'd65535;  cnt = 32'd1;    end
                5:       begin thr = 32'd0;      cnt = 32'd1023; end
                default:
                begin
                    thr = $urandom_range(0, 131071);
                    cnt = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(0, 2047);
                end
            endcase
            cfg_write(REG_THRESHOLD, thr);
            cfg_write(REG_NODE_COUNT, cnt);
            cfg_check(REG_THRESHOLD, thr);
            cfg_check(REG_NODE_COUNT, cnt);
            for (int i = 0; i < WORDS_PER_PHASE; i++)
            begin
                if (i % 50 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                send_word(make_word());
            end
            drain();
        end

        repeat (40) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.report("results still missing at end of run");
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
